// ----- rtl/core/atpgd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atpgd_pkg: shared types and constants of the triple-peak gesture detector
// Register indexes, reset values, pitch band limits and the control structs
// that pass between the lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package atpgd_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_THRESHOLD    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_LENGTH        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_GAP_MS       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_TIMEOUT_MS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOMINANCE_Q8      = 3'd4;

    localparam logic [14:0] PEAK_THRESHOLD_RST    = 15'd8192;
    localparam logic [3:0]  RUN_LENGTH_RST        = 4'd3;
    localparam logic [15:0] PEAK_GAP_MS_RST       = 16'd300;
    localparam logic [15:0] MOTION_TIMEOUT_MS_RST = 16'd1000;
    localparam logic [8:0]  DOMINANCE_Q8_RST      = 9'd205;

    // signed compare width for sample against threshold
    localparam int CMP_W = 17;

    // pitch bands, hundredths of a degree
    localparam logic signed [15:0] PITCH_LOW_CD  = -16'sd4500;
    localparam logic signed [15:0] PITCH_HIGH_CD = 16'sd4500;
    localparam logic [4:0] BAND_LOW  = 5'd0;
    localparam logic [4:0] BAND_MID  = 5'd6;
    localparam logic [4:0] BAND_HIGH = 5'd12;

    localparam logic [1:0] PEAKS_NONE  = 2'd0;
    localparam logic [1:0] PEAKS_ONE   = 2'd1;
    localparam logic [1:0] PEAKS_THREE = 2'd3;

    // merge stage to lanes
    typedef struct packed {
        logic expire;         // motion timed out: clear, keep old direction
        logic gesture_clear;  // gesture accepted: clear, keep new direction
    } lane_ctrl_t;

    // lane to merge stage
    typedef struct packed {
        logic [1:0] peaks;
        logic       first_pos;
    } lane_flags_t;

    // one result word
    typedef struct packed {
        logic       valid;
        logic [4:0] code;
    } gesture_t;

endpackage
`default_nettype wire

// ----- rtl/core/atpgd_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atpgd_ifs: valid/ready channels of the gesture detector
// Sample channel carries the three axes, pitch and timestamp; the gesture
// channel carries one result word per sample.
// ----------------------------------------------------------------------------
interface atpgd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic signed [15:0]            pitch_centideg;
    logic [31:0]                   now_ms;

    modport source (output valid, sample_x, sample_y, sample_z, pitch_centideg, now_ms,
                    input ready);
    modport sink   (input valid, sample_x, sample_y, sample_z, pitch_centideg, now_ms,
                    output ready);
endinterface

interface atpgd_gesture_if;
    logic       valid;
    logic       ready;
    logic       gesture_valid;
    logic [4:0] gesture_code;

    modport source (output valid, gesture_valid, gesture_code, input ready);
    modport sink   (input valid, gesture_valid, gesture_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/atpgd_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atpgd_lane: peak tracker of one axis
// Holds the run counters, peak count, direction, last peak time and largest
// magnitude of one axis and computes their update for every accepted word.
// ----------------------------------------------------------------------------
module atpgd_lane
    import atpgd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample,
    input  wire logic [31:0]                         now_ms,
    input  wire logic [14:0]                         peak_threshold,
    input  wire logic [3:0]                          run_length,
    input  wire logic [15:0]                         peak_gap_ms,
    input  wire logic [8:0]                          dominance_q8,
    input  wire lane_ctrl_t                          ctrl,
    output      lane_flags_t                         flags_next,
    output      logic [SAMPLE_BITS-1:0]              largest_next,
    output      logic [SAMPLE_BITS+8:0]              product_next
);

    localparam int PW = SAMPLE_BITS + 9;

    logic [3:0]             pos_run_reg,   pos_run_next;
    logic [3:0]             neg_run_reg,   neg_run_next;
    logic [1:0]             peaks_reg,     peaks_next;
    logic                   first_pos_reg, first_pos_next;
    logic [31:0]            last_peak_reg, last_peak_next;
    logic [SAMPLE_BITS-1:0] largest_reg;

    logic signed [CMP_W-1:0] s_ext;
    logic signed [CMP_W-1:0] th;
    logic                    above;
    logic                    below;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [3:0]              pr;
    logic [3:0]              nr;
    logic [1:0]              pk;
    logic [31:0]             lp;
    logic [SAMPLE_BITS-1:0]  lm;
    logic                    gap_expired;
    logic                    want_pos;
    logic [PW-1:0]           mag_prod;
    logic [PW-1:0]           old_prod;

    assign s_ext = CMP_W'(sample);
    assign th    = signed'({{(CMP_W-15){1'b0}}, peak_threshold});
    assign above = s_ext > th;
    assign below = s_ext < -th;
    assign mag   = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample + 1'b1)
                                         : SAMPLE_BITS'(sample);

    always_comb
    begin
        // an axis still holding three peaks starts over
        if (peaks_reg == PEAKS_THREE)
        begin
            pr = '0;
            nr = '0;
            pk = PEAKS_NONE;
            lp = now_ms;
            lm = '0;
        end
        else
        begin
            pr = pos_run_reg;
            nr = neg_run_reg;
            pk = peaks_reg;
            lp = last_peak_reg;
            lm = largest_reg;
        end

        gap_expired    = 1'b0;
        want_pos       = 1'b0;
        first_pos_next = first_pos_reg;
        pos_run_next   = pr;
        neg_run_next   = nr;
        peaks_next     = pk;
        last_peak_next = lp;

        if (pk == PEAKS_NONE)
        begin
            priority if (above)
                pos_run_next = pr + 4'd1;
            else if (below)
                neg_run_next = nr + 4'd1;
            else
            begin
                pos_run_next = '0;
                neg_run_next = '0;
            end
            priority if (pos_run_next == run_length)
            begin
                pos_run_next   = '0;
                first_pos_next = 1'b1;
                peaks_next     = PEAKS_ONE;
                last_peak_next = now_ms;
            end
            else if (neg_run_next == run_length)
            begin
                neg_run_next   = '0;
                first_pos_next = 1'b0;
                peaks_next     = PEAKS_ONE;
                last_peak_next = now_ms;
            end
            else
            begin
                // no peak yet: keep counting
            end
        end
        else if ((now_ms - lp) > {16'd0, peak_gap_ms})
        begin
            gap_expired    = 1'b1;
            pos_run_next   = '0;
            neg_run_next   = '0;
            peaks_next     = PEAKS_NONE;
            last_peak_next = now_ms;
        end
        else
        begin
            // second peak opposes the first, third repeats it
            want_pos = (pk == PEAKS_ONE) ? !first_pos_reg : first_pos_reg;
            if (want_pos)
                pos_run_next = above ? pr + 4'd1 : 4'd0;
            else
                neg_run_next = below ? nr + 4'd1 : 4'd0;
            if (pos_run_next == run_length || neg_run_next == run_length)
            begin
                pos_run_next   = '0;
                neg_run_next   = '0;
                peaks_next     = pk + 2'd1;
                last_peak_next = now_ms;
            end
        end
    end

    // dominance products of both candidates side by side, then select
    assign mag_prod = PW'(mag) * PW'(dominance_q8);
    assign old_prod = PW'(lm) * PW'(dominance_q8);

    always_comb
    begin
        if (gap_expired)
        begin
            largest_next = '0;
            product_next = '0;
        end
        else if (lm < mag)
        begin
            largest_next = mag;
            product_next = mag_prod;
        end
        else
        begin
            largest_next = lm;
            product_next = old_prod;
        end
    end

    assign flags_next.peaks     = peaks_next;
    assign flags_next.first_pos = first_pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_run_reg   <= '0;
            neg_run_reg   <= '0;
            peaks_reg     <= PEAKS_NONE;
            first_pos_reg <= 1'b0;
            last_peak_reg <= '0;
            largest_reg   <= '0;
        end
        else if (accept)
        begin
            if (ctrl.expire || ctrl.gesture_clear)
            begin
                pos_run_reg   <= '0;
                neg_run_reg   <= '0;
                peaks_reg     <= PEAKS_NONE;
                last_peak_reg <= now_ms;
                largest_reg   <= '0;
                // expiry drops the word: hold the old direction
                if (!ctrl.expire)
                    first_pos_reg <= first_pos_next;
            end
            else
            begin
                pos_run_reg   <= pos_run_next;
                neg_run_reg   <= neg_run_next;
                peaks_reg     <= peaks_next;
                first_pos_reg <= first_pos_next;
                last_peak_reg <= last_peak_next;
                largest_reg   <= largest_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/atpgd_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atpgd_merge: combines the lane results into one gesture decision
// Tracks the motion window, picks the first axis with three peaks, checks
// dominance over the other axes and forms the gesture code.
// ----------------------------------------------------------------------------
module atpgd_merge
    import atpgd_pkg::*;
#(
    parameter int NUM_AXES    = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [31:0]            now_ms,
    input  wire logic signed [15:0]     pitch_centideg,
    input  wire logic [15:0]            motion_timeout_ms,
    input  wire lane_flags_t            flags_next   [NUM_AXES],
    input  wire logic [SAMPLE_BITS-1:0] largest_next [NUM_AXES],
    input  wire logic [SAMPLE_BITS+8:0] product_next [NUM_AXES],
    output      lane_ctrl_t             ctrl,
    output      gesture_t               result
);

    logic        active_reg, active_next;
    logic [31:0] start_reg,  start_next;

    logic          expire;
    logic          any_first;
    logic          found;
    logic          accepted;
    logic [4:0]    band;
    logic [4:0]    code;
    logic [NUM_AXES-1:0] dominant;

    assign expire = active_reg && ((now_ms - start_reg) > {16'd0, motion_timeout_ms});

    always_comb
    begin
        priority if (pitch_centideg < PITCH_LOW_CD)
            band = BAND_LOW;
        else if (pitch_centideg < PITCH_HIGH_CD)
            band = BAND_MID;
        else
            band = BAND_HIGH;
    end

    // each axis against every other one
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dominant[a] = 1'b1;
            for (int o = 0; o < NUM_AXES; o++)
            begin
                if (o != a && !(product_next[a] > {largest_next[o], 8'd0}))
                    dominant[a] = 1'b0;
            end
        end
    end

    // only the first axis with three peaks is examined
    always_comb
    begin
        found     = 1'b0;
        accepted  = 1'b0;
        code      = '0;
        any_first = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (flags_next[a].peaks == PEAKS_ONE)
                any_first = 1'b1;
            if (!found && flags_next[a].peaks == PEAKS_THREE)
            begin
                found    = 1'b1;
                accepted = dominant[a];
                code     = 5'(2 * a + 1) + {4'd0, flags_next[a].first_pos} + band;
            end
        end
    end

    assign ctrl.expire        = expire;
    assign ctrl.gesture_clear = !expire && accepted;

    assign result.valid = ctrl.gesture_clear;
    assign result.code  = ctrl.gesture_clear ? code : 5'd0;

    always_comb
    begin
        active_next = active_reg;
        start_next  = start_reg;
        if (expire || accepted)
        begin
            active_next = 1'b0;
            start_next  = now_ms;
        end
        else if (!active_reg && any_first)
        begin
            active_next = 1'b1;
            start_next  = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            start_reg  <= start_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/accel_triple_peak_gesture_detector_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// accel_triple_peak_gesture_detector_top: triple-peak gesture detector
// One accelerometer sample in, one gesture word out, one lane per axis.
// ----------------------------------------------------------------------------
// Usage:
//   samples  : valid/ready sink. Each word is one accelerometer sample (x, y,
//              z, pitch, millisecond timestamp) and is taken on valid & ready.
//   gestures : valid/ready source. Exactly one word per sample, in order:
//              gesture_valid high and gesture_code set when that sample
//              completed an accepted gesture, otherwise both zero.
//   cfg_*    : write port for the five registers; write only while idle.
// Each taken sample's word is registered into the output buffer. Throughput
// is one sample per cycle while the buffer has room; the per-axis lane update
// and the merge decision are both combinational, since each sample needs the
// state the previous one left.
// A two-word output buffer decouples the channels: samples keep flowing while
// a word waits, and ready drops only once two words are unclaimed. When the
// receiver stalls, held words stay put and are delivered in order.
// Reset clears all tracking state, empties the buffer and loads the register
// defaults (threshold 8192, run 3, gap 300 ms, timeout 1000 ms, ratio 205).
// ----------------------------------------------------------------------------
module accel_triple_peak_gesture_detector_top
    import atpgd_pkg::*;
#(
    parameter int NUM_AXES    = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    atpgd_sample_if.sink                samples,
    atpgd_gesture_if.source             gestures,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // ---------------- configuration registers ----------------
    logic [14:0] peak_threshold_reg;
    logic [3:0]  run_length_reg;
    logic [15:0] peak_gap_ms_reg;
    logic [15:0] motion_timeout_ms_reg;
    logic [8:0]  dominance_q8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_threshold_reg    <= PEAK_THRESHOLD_RST;
            run_length_reg        <= RUN_LENGTH_RST;
            peak_gap_ms_reg       <= PEAK_GAP_MS_RST;
            motion_timeout_ms_reg <= MOTION_TIMEOUT_MS_RST;
            dominance_q8_reg      <= DOMINANCE_Q8_RST;
        end
        else if (cfg_wr_en)
        begin
            // indexes beyond the list are dropped
            unique case (cfg_index)
                CFG_PEAK_THRESHOLD:    peak_threshold_reg    <= cfg_data[14:0];
                CFG_RUN_LENGTH:        run_length_reg        <= cfg_data[3:0];
                CFG_PEAK_GAP_MS:       peak_gap_ms_reg       <= cfg_data;
                CFG_MOTION_TIMEOUT_MS: motion_timeout_ms_reg <= cfg_data;
                CFG_DOMINANCE_Q8:      dominance_q8_reg      <= cfg_data[8:0];
                default:               ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign samples.ready = (count_reg != 2'd2);
    assign push          = samples.valid && samples.ready;
    assign pop           = gestures.valid && gestures.ready;

    // ---------------- axis lanes ----------------
    logic signed [SAMPLE_BITS-1:0] lane_sample  [NUM_AXES];
    lane_flags_t                   flags_next   [NUM_AXES];
    logic [SAMPLE_BITS-1:0]        largest_next [NUM_AXES];
    logic [SAMPLE_BITS+8:0]        product_next [NUM_AXES];
    lane_ctrl_t                    lane_ctrl;
    gesture_t                      result;

    assign lane_sample[0] = samples.sample_x;
    if (NUM_AXES > 1)
    begin : g_axis_y
        assign lane_sample[1] = samples.sample_y;
    end
    if (NUM_AXES > 2)
    begin : g_axis_z
        assign lane_sample[2] = samples.sample_z;
    end

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        atpgd_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .accept         (push),
            .sample         (lane_sample[g]),
            .now_ms         (samples.now_ms),
            .peak_threshold (peak_threshold_reg),
            .run_length     (run_length_reg),
            .peak_gap_ms    (peak_gap_ms_reg),
            .dominance_q8   (dominance_q8_reg),
            .ctrl           (lane_ctrl),
            .flags_next     (flags_next[g]),
            .largest_next   (largest_next[g]),
            .product_next   (product_next[g])
        );
    end

    // ---------------- merge ----------------
    atpgd_merge #(
        .NUM_AXES    (NUM_AXES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (push),
        .now_ms            (samples.now_ms),
        .pitch_centideg    (samples.pitch_centideg),
        .motion_timeout_ms (motion_timeout_ms_reg),
        .flags_next        (flags_next),
        .largest_next      (largest_next),
        .product_next      (product_next),
        .ctrl              (lane_ctrl),
        .result            (result)
    );

    // ---------------- two-word output buffer ----------------
    // head_reg drives the port, tail_reg holds a second word during a stall
    gesture_t head_reg, head_next;
    gesture_t tail_reg, tail_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    head_next = result;
                else
                    tail_next = result;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                // advance: the word behind the head moves up, the new word follows
                if (count_reg == 2'd2)
                begin
                    head_next = tail_reg;
                    tail_next = result;
                end
                else
                    head_next = result;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign gestures.valid         = (count_reg != 2'd0);
    assign gestures.gesture_valid = head_reg.valid;
    assign gestures.gesture_code  = head_reg.code;

    // ---------------- assertions ----------------
    // a reported gesture carries a code from the defined range, none carries zero
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (result.valid ? (result.code >= 5'd1 && result.code <= 5'd18)
                               : (result.code == 5'd0)))
        else $error("gesture code out of range");

    // a drain without a new word shrinks the buffer by one
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("output buffer count lost track on drain");

    // a word taken into an empty buffer is offered on the next cycle
    a_offer: assert property (@(posedge clk) disable iff (!rst_n)
        (push && count_reg == 2'd0) |=> gestures.valid)
        else $error("accepted word not offered");

    // a stalled full buffer neither overfills nor changes its head word
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> (count_reg == 2'd2 && $stable(head_reg)))
        else $error("stalled full buffer changed");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the triple-peak gesture detector
// Drives accelerometer sample words through the valid/ready sink, predicts
// each gesture word with an in-bench peak tracker, and checks every gesture
// word in order. Runs a directed opening, then nine register settings with
// well-formed triple-peak gestures mixed with noise, under three idle patterns.
// ----------------------------------------------------------------------------
module tb_top
    import atpgd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_WORDS  = 44;
    localparam int NUM_PHASES   = 9;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] pitch;
        logic [31:0]        stamp;
    } accel_word_t;

    logic clk;
    logic rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    atpgd_sample_if #(.SAMPLE_BITS(16)) sample_ch ();
    atpgd_gesture_if                    gesture_ch ();

    accel_triple_peak_gesture_detector_top #(
        .NUM_AXES    (3),
        .SAMPLE_BITS (16)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .gestures  (gesture_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register shadows, as the block holds them after reset.
    logic [14:0] peak_thr   = PEAK_THRESHOLD_RST;
    logic [3:0]  run_len    = RUN_LENGTH_RST;
    logic [15:0] gap_ms     = PEAK_GAP_MS_RST;
    logic [15:0] timeout_ms = MOTION_TIMEOUT_MS_RST;
    logic [8:0]  dom_q8     = DOMINANCE_Q8_RST;

    // Tracker state, one entry per axis (x, y, z), all zero after reset.
    logic [3:0]  pos_run_q   [3] = '{default: '0};
    logic [3:0]  neg_run_q   [3] = '{default: '0};
    logic [1:0]  peaks_q     [3] = '{default: '0};
    logic        first_pos_q [3] = '{default: '0};
    logic [31:0] last_peak_q [3] = '{default: '0};
    logic [15:0] max_mag_q   [3] = '{default: '0};
    logic        motion_on = 1'b0;
    logic [31:0] motion_t0 = '0;

    accel_word_t pending_samples[$];
    gesture_t    predicted_gestures[$];

    int          mismatch_count = 0;
    int          checked_words  = 0;
    int          stall_cycles   = 0;
    int          send_idle_pct  = 8;
    int          recv_idle_pct  = 59;
    logic        sample_taken;
    logic [31:0] stamp;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Peak tracker
    // ------------------------------------------------------------------

    // Drop runs, peaks and the magnitude; the direction of the first peak
    // survives an axis clear.
    function automatic void clear_axis(int a, logic [31:0] now);
        pos_run_q[a]   = '0;
        neg_run_q[a]   = '0;
        peaks_q[a]     = PEAKS_NONE;
        last_peak_q[a] = now;
        max_mag_q[a]   = '0;
    endfunction

    function automatic void clear_motion(logic [31:0] now);
        int a;
        motion_on = 1'b0;
        motion_t0 = now;
        for (a = 0; a < 3; a++)
            clear_axis(a, now);
    endfunction

    function automatic void track_axis(int a, int s, logic [31:0] now);
        int          th;
        logic        above;
        logic        below;
        logic        want_pos;
        logic [15:0] mag;
        th    = int'(peak_thr);
        above = s > th;
        below = s < -th;

        // A rejected gesture leaves three peaks behind: start over first.
        if (peaks_q[a] == PEAKS_THREE)
            clear_axis(a, now);

        if (peaks_q[a] == PEAKS_NONE) begin
            if (above)
                pos_run_q[a] = pos_run_q[a] + 4'd1;
            else if (below)
                neg_run_q[a] = neg_run_q[a] + 4'd1;
            else begin
                pos_run_q[a] = '0;
                neg_run_q[a] = '0;
            end
            if (pos_run_q[a] == run_len) begin
                pos_run_q[a]   = '0;
                first_pos_q[a] = 1'b1;
                peaks_q[a]     = PEAKS_ONE;
                last_peak_q[a] = now;
            end else if (neg_run_q[a] == run_len) begin
                neg_run_q[a]   = '0;
                first_pos_q[a] = 1'b0;
                peaks_q[a]     = PEAKS_ONE;
                last_peak_q[a] = now;
            end
        end else begin
            // Gap expired: clear and skip the magnitude for this word.
            if ((now - last_peak_q[a]) > 32'(gap_ms)) begin
                clear_axis(a, now);
                return;
            end
            want_pos = (peaks_q[a] == PEAKS_ONE) ? !first_pos_q[a] : first_pos_q[a];
            if (want_pos)
                pos_run_q[a] = above ? pos_run_q[a] + 4'd1 : 4'd0;
            else
                neg_run_q[a] = below ? neg_run_q[a] + 4'd1 : 4'd0;
            // A run left over from the first phase may complete this peak.
            if (pos_run_q[a] == run_len || neg_run_q[a] == run_len) begin
                pos_run_q[a]   = '0;
                neg_run_q[a]   = '0;
                peaks_q[a]     = peaks_q[a] + 2'd1;
                last_peak_q[a] = now;
            end
        end

        mag = (s < 0) ? 16'(-s) : 16'(s);
        if (max_mag_q[a] < mag)
            max_mag_q[a] = mag;
    endfunction

    function automatic gesture_t predict_gesture(accel_word_t w);
        gesture_t    g;
        int          s [3];
        int          a;
        int          o;
        logic        examined;
        logic        dominant;
        logic [31:0] lhs;
        logic [4:0]  band;
        g = '0;

        // Motion expiry: clear everything and drop the word.
        if (motion_on && (w.stamp - motion_t0) > 32'(timeout_ms)) begin
            clear_motion(w.stamp);
            return g;
        end

        s[0] = int'(w.x);
        s[1] = int'(w.y);
        s[2] = int'(w.z);
        for (a = 0; a < 3; a++)
            track_axis(a, s[a], w.stamp);

        if (!motion_on) begin
            for (a = 0; a < 3; a++) begin
                if (!motion_on && peaks_q[a] == PEAKS_ONE) begin
                    motion_on = 1'b1;
                    motion_t0 = w.stamp;
                end
            end
        end

        // Only the first axis holding three peaks gets a say.
        examined = 1'b0;
        for (a = 0; a < 3; a++) begin
            if (!examined && peaks_q[a] == PEAKS_THREE) begin
                examined = 1'b1;
                dominant = 1'b1;
                lhs = 32'(max_mag_q[a]) * 32'(dom_q8);
                for (o = 0; o < 3; o++)
                    if (o != a && !(lhs > 32'(max_mag_q[o]) * 32'd256))
                        dominant = 1'b0;
                if (dominant) begin
                    band = (w.pitch < PITCH_LOW_CD)  ? BAND_LOW :
                           (w.pitch < PITCH_HIGH_CD) ? BAND_MID : BAND_HIGH;
                    g.valid = 1'b1;
                    g.code  = 5'd1 + 5'(2 * a) + {4'd0, first_pos_q[a]} + band;
                    clear_motion(w.stamp);
                end
            end
        end
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Sample both channels at the rising edge; predict on each accepted
    // sample word before matching the gesture word, so ordering holds even
    // if the result showed up in the same cycle.
    always @(posedge clk or negedge rst_n) begin
        accel_word_t w;
        gesture_t    want;
        if (!rst_n) begin
            sample_taken <= 1'b0;
            stall_cycles <= 0;
        end else begin
            sample_taken <= sample_ch.valid && sample_ch.ready;
            if (sample_ch.valid && sample_ch.ready) begin
                w.x     = sample_ch.sample_x;
                w.y     = sample_ch.sample_y;
                w.z     = sample_ch.sample_z;
                w.pitch = sample_ch.pitch_centideg;
                w.stamp = sample_ch.now_ms;
                predicted_gestures.push_back(predict_gesture(w));
            end
            if (gesture_ch.valid && gesture_ch.ready) begin
                if (predicted_gestures.size() == 0) begin
                    report_mismatch("gesture word with no sample outstanding");
                end else begin
                    want = predicted_gestures.pop_front();
                    if (gesture_ch.gesture_valid !== want.valid)
                        report_mismatch($sformatf("word %0d gesture_valid got %b want %b",
                            checked_words, gesture_ch.gesture_valid, want.valid));
                    if (gesture_ch.gesture_code !== want.code)
                        report_mismatch($sformatf("word %0d gesture_code got %0d want %0d",
                            checked_words, gesture_ch.gesture_code, want.code));
                end
                checked_words++;
            end
            // Watchdog: count cycles where neither channel moves a word.
            if ((sample_ch.valid && sample_ch.ready) || (gesture_ch.valid && gesture_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("[accel_triple_peak_gesture_detector_top] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving, on the falling edge
    // ------------------------------------------------------------------

    // Hold the current word until it is taken, then advance to the next
    // pending word or go idle.
    always @(negedge clk) begin
        accel_word_t nxt;
        if (!rst_n) begin
            sample_ch.valid <= 1'b0;
        end else if (!sample_ch.valid || sample_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_samples.pop_front();
                sample_ch.valid          <= 1'b1;
                sample_ch.sample_x       <= nxt.x;
                sample_ch.sample_y       <= nxt.y;
                sample_ch.sample_z       <= nxt.z;
                sample_ch.pitch_centideg <= nxt.pitch;
                sample_ch.now_ms         <= nxt.stamp;
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n)
            gesture_ch.ready <= 1'b0;
        else
            gesture_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_sample(int x, int y, int z, int pitch, int unsigned step);
        accel_word_t w;
        stamp   = stamp + step;
        w.x     = 16'(x);
        w.y     = 16'(y);
        w.z     = 16'(z);
        w.pitch = 16'(pitch);
        w.stamp = stamp;
        pending_samples.push_back(w);
    endtask

    // Signed value inside +/- lim.
    function automatic int quiet_value(int lim);
        int q;
        q = int'($urandom_range(lim));
        if ($urandom_range(1))
            q = -q;
        return q;
    endfunction

    // Lean on the band edges; otherwise anywhere in +/-180 degrees.
    function automatic int pick_pitch();
        int p;
        case ($urandom_range(9))
            0:       p = -18000;
            1:       p = 18000;
            2:       p = -4500;
            3:       p = -4501;
            4:       p = 4499;
            5:       p = 4500;
            default: p = int'($urandom_range(36000)) - 18000;
        endcase
        return p;
    endfunction

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every queued word is taken and every gesture word checked.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid
               || predicted_gestures.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          phase;
        int          k;
        int          p;
        int          axis;
        int          rl;
        int          lim;
        int          widest;
        int          lim_quiet;
        int          queued;
        int          t_thr;
        int          t_run;
        int          t_gap;
        int          t_tmo;
        int          t_dom;
        int          v [3];
        logic        dir;
        logic        pos;
        int unsigned step;

        // Known values on every input from time zero.
        rst_n                    = 1'b0;
        cfg_wr_en                = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.sample_x       = '0;
        sample_ch.sample_y       = '0;
        sample_ch.sample_z       = '0;
        sample_ch.pitch_centideg = '0;
        sample_ch.now_ms         = '0;
        gesture_ch.ready         = 1'b0;
        stamp                    = 32'hFFFF_FFF0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening at the reset settings. Start near the top of the
        // timestamp range so the first gesture straddles the wrap.
        queue_sample(32767, -32768, 0, 0, 0);
        queue_sample(-32768, 32767, -1, 18000, 7);
        queue_sample(0, 0, 0, -18000, 5);
        // x gesture, positive first, lowest pitch band
        for (p = 0; p < 3; p++)
            for (k = 0; k < 3; k++)
                queue_sample((p == 1) ? -20000 : 20000, 100, -100, -18000, 10);
        // z gesture, negative first, pitch right on the upper band edge
        for (p = 0; p < 3; p++)
            for (k = 0; k < 3; k++)
                queue_sample(-50, 70, (p == 1) ? 30000 : -30000, 4500, 12);
        // quiet word, long jump, pitch on the lower band edge
        queue_sample(0, 0, 0, -4500, 5000);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();

            // Reset settings and extremes first, then random settings that still let gestures form.
            case (phase)
                0: begin
                    t_thr = PEAK_THRESHOLD_RST;  t_run = RUN_LENGTH_RST;
                    t_gap = PEAK_GAP_MS_RST;     t_tmo = MOTION_TIMEOUT_MS_RST;
                    t_dom = DOMINANCE_Q8_RST;
                end
                1: begin
                    t_thr = 0;     t_run = 1;  t_gap = 0;     t_tmo = 0;     t_dom = 0;
                end
                2: begin
                    t_thr = 32767; t_run = 15; t_gap = 65535; t_tmo = 65535; t_dom = 511;
                end
                3: begin
                    // run length zero only fires after a wrap or on a cleared run
                    t_thr = 4000;  t_run = 0;  t_gap = 100;   t_tmo = 500;   t_dom = 256;
                end
                default: begin
                    t_thr = int'($urandom_range(20000, 1000));
                    t_run = int'($urandom_range(4, 1));
                    t_gap = int'($urandom_range(400, 20));
                    t_tmo = int'($urandom_range(2000, 100));
                    t_dom = int'($urandom_range(300, 150));
                end
            endcase
            write_register(CFG_PEAK_THRESHOLD, 16'(t_thr));
            write_register(CFG_RUN_LENGTH, 16'(t_run));
            write_register(CFG_PEAK_GAP_MS, 16'(t_gap));
            write_register(CFG_MOTION_TIMEOUT_MS, 16'(t_tmo));
            write_register(CFG_DOMINANCE_Q8, 16'(t_dom));
            peak_thr   = 15'(t_thr);
            run_len    = 4'(t_run);
            gap_ms     = 16'(t_gap);
            timeout_ms = 16'(t_tmo);
            dom_q8     = 9'(t_dom);

            // Sender busy and receiver choked, then swapped, then flat out.
            case (phase / 3)
                0:       begin send_idle_pct = 8;  recv_idle_pct = 59; end
                1:       begin send_idle_pct = 59; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase

            rl     = (t_run == 0) ? 16 : t_run;
            lim    = ((t_gap < t_tmo) ? t_gap : t_tmo) / (3 * rl + 3);
            widest = ((t_gap > t_tmo) ? t_gap : t_tmo) * 3 + 3;
            queued = 0;
            while (queued < PHASE_WORDS) begin
                if ($urandom_range(3) != 0) begin
                    // Well-formed triple peak on one axis with random content.
                    axis      = int'($urandom_range(2));
                    dir       = 1'($urandom_range(1));
                    lim_quiet = ($urandom_range(3) == 0) ? t_thr : t_thr * 3 / 4;
                    for (p = 0; p < 3; p++) begin
                        pos = (p == 1) ? !dir : dir;
                        if ($urandom_range(5) == 0) begin
                            queue_sample(quiet_value(t_thr), quiet_value(t_thr),
                                         quiet_value(t_thr), pick_pitch(),
                                         $urandom_range(lim));
                            queued++;
                        end
                        for (k = 0; k < rl; k++) begin
                            v[0] = quiet_value(lim_quiet);
                            v[1] = quiet_value(lim_quiet);
                            v[2] = quiet_value(lim_quiet);
                            if (pos)
                                v[axis] = (t_thr == 32767) ? 32767
                                        : int'($urandom_range(32767, t_thr + 1));
                            else
                                v[axis] = -int'($urandom_range(32768, t_thr + 1));
                            // Now and then break the gap or the motion window.
                            step = ($urandom_range(11) == 0) ? $urandom_range(widest)
                                                             : $urandom_range(lim);
                            queue_sample(v[0], v[1], v[2], pick_pitch(), step);
                            queued++;
                        end
                    end
                end else begin
                    // Noise: any sample values, occasional huge timestamp jumps.
                    for (k = 0; k < int'($urandom_range(4, 1)); k++) begin
                        step = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200);
                        queue_sample(int'($signed(16'($urandom))),
                                     int'($signed(16'($urandom))),
                                     int'($signed(16'($urandom))),
                                     pick_pitch(), step);
                        queued++;
                    end
                end
            end
        end

        wait_drained();
        // Let a stray late word show up before the verdict.
        repeat (4) @(negedge clk);
        if (mismatch_count == 0)
            $display("[accel_triple_peak_gesture_detector_top] OK");
        else
            $display("[accel_triple_peak_gesture_detector_top] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
